/* design/pps_pkg.sv */
// Package for the rotated-rectangle point picker.
// Holds sequencer states, the slot table word layout and the CORDIC constants.
// No dependencies.
`default_nettype none

package pps_pkg;

    localparam int TURN          = 92160;
    localparam int QUARTER       = 23040;
    localparam int CORDIC_X0     = 39797;
    localparam int CORDIC_STEPS  = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_WRITE,
        ST_TRD,
        ST_TSTART,
        ST_TWAIT,
        ST_TEVAL,
        ST_MOD,
        ST_RK,
        ST_RKLD,
        ST_RSW,
        ST_RDRAIN,
        ST_RCHK,
        ST_OUT
    } pps_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_PREP,
        CS_ITER,
        CS_DONE
    } pps_cordic_state_t;

    // One slot of the rectangle table.
    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [15:0]        w;
        logic [15:0]        h;
        logic signed [17:0] c;
        logic signed [17:0] s;
        logic signed [15:0] layer;
    } pps_entry_t;

    // Result of one containment test.
    typedef struct packed {
        logic done;
        logic hit;
    } pps_hit_res_t;

    // Arctangent of 2^-i in units of 2^-16 degree.
    function automatic logic signed [24:0] atan_at(input logic [3:0] i);
        logic signed [24:0] v;
        unique case (i)
            4'd0:    v = 25'sd2949120;
            4'd1:    v = 25'sd1740967;
            4'd2:    v = 25'sd919879;
            4'd3:    v = 25'sd466945;
            4'd4:    v = 25'sd234379;
            4'd5:    v = 25'sd117304;
            4'd6:    v = 25'sd58666;
            4'd7:    v = 25'sd29335;
            4'd8:    v = 25'sd14668;
            4'd9:    v = 25'sd7334;
            4'd10:   v = 25'sd3667;
            4'd11:   v = 25'sd1833;
            4'd12:   v = 25'sd917;
            4'd13:   v = 25'sd458;
            4'd14:   v = 25'sd229;
            default: v = 25'sd115;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* design/pps_in_if.sv */
// Input channel of the point picker: valid/ready handshake and one input word.
// No dependencies.
`default_nettype none

interface pps_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [5:0]         slot;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        size_x;
    logic [15:0]        size_y;
    logic [16:0]        angle;
    logic signed [15:0] layer;
    logic               pickable;
    logic               advance;

    modport source (output valid, func, slot, pos_x, pos_y, size_x, size_y, angle,
                    layer, pickable, advance, input ready);
    modport sink   (input valid, func, slot, pos_x, pos_y, size_x, size_y, angle,
                    layer, pickable, advance, output ready);
endinterface

`default_nettype wire

/* design/pps_out_if.sv */
// Output channel of the point picker: valid/ready handshake and one result word.
// No dependencies.
`default_nettype none

interface pps_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [5:0] picked_slot;
    logic [6:0] hit_total;

    modport source (output valid, found, picked_slot, hit_total, input ready);
    modport sink   (input valid, found, picked_slot, hit_total, output ready);
endinterface

`default_nettype wire

/* design/point_pick_rotated_sprites_top.sv */
// Top level of the rotated-rectangle point picker: sequencer, slot table and
// result register. Depends on pps_pkg, pps_in_if, pps_out_if, pps_cordic, pps_hit.
//
// Usage. Words arrive on req and results leave on rsp, both valid/ready.
// A load word (func 0) writes one slot of the table: centre, size, layer,
// the pickable flag and the cosine and sine of its angle. It gives no result;
// the 16-step CORDIC runs first, then the slot is written.
// A query word (func 1) gives exactly one result word. The test pass reads
// each pickable slot and runs the multiply sequence on it, and passes over
// every other slot. Ranking then walks the hits in slot order; for each
// candidate it sweeps the whole table, until the candidate of the wanted
// rank is met. The single table read port and the one multiplier bound
// the speed of a query.
// req.ready is high only while the block is idle. A finished result sits in
// the output register; the next word is taken while it waits, and a second
// result waits in the sequencer until rsp.ready frees the register.
// Reset clears every pickable flag and the earlier pick at once, so the
// block is ready straight out of reset.
`default_nettype none

module point_pick_rotated_sprites_top #(
    parameter int SLOTS = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pps_in_if.sink    req,
    pps_out_if.source rsp
);
    import pps_pkg::*;

    // The slot field reaches 64 slots at most.
    localparam int DEPTH = (SLOTS < 64) ? SLOTS : 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    pps_state_t         state_reg, state_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [AW-1:0]      cidx_reg, cidx_next;
    logic               cmpv_reg, cmpv_next;
    logic [6:0]         rank_reg, rank_next;
    logic [6:0]         total_reg, total_next;
    logic [6:0]         want_reg, want_next;
    logic               last_valid_reg, last_valid_next;
    logic [6:0]         last_pick_reg, last_pick_next;
    logic               found_reg, found_next;
    logic [DEPTH-1:0]   hit_reg, hit_next;
    logic [DEPTH-1:0]   en_reg, en_next;
    logic signed [15:0] layer_k_reg, layer_k_next;
    logic               ovalid_reg, ovalid_next;
    logic               ofound_reg, ofound_next;
    logic [5:0]         oslot_reg, oslot_next;
    logic [6:0]         ototal_reg, ototal_next;

    // Latched input word.
    logic [5:0]         item_slot_reg;
    logic signed [23:0] item_px_reg, item_py_reg;
    logic [15:0]        item_sx_reg, item_sy_reg;
    logic signed [15:0] item_layer_reg;
    logic               item_pick_reg, item_adv_reg;
    logic signed [17:0] cos_reg, sin_reg;

    pps_entry_t         mem [DEPTH];
    pps_entry_t         rd_data_reg;
    pps_entry_t         wr_data;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      k_idx;

    logic               accept;
    logic               cordic_start, cordic_done;
    logic signed [17:0] cordic_cos, cordic_sin;
    logic               hit_start;
    pps_hit_res_t       hit_res;
    logic               slot_ok;
    logic               beats;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign k_idx     = k_reg[AW-1:0];
    assign slot_ok   = ({1'b0, item_slot_reg} < 7'(DEPTH));

    assign cordic_start = accept && !req.func;

    pps_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (req.angle),
        .done    (cordic_done),
        .cos_val (cordic_cos),
        .sin_val (cordic_sin)
    );

    pps_hit u_hit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hit_start),
        .px    (item_px_reg),
        .py    (item_py_reg),
        .entry (rd_data_reg),
        .res   (hit_res)
    );

    // Slot table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[item_slot_reg[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        wr_data.cx    = item_px_reg;
        wr_data.cy    = item_py_reg;
        wr_data.w     = item_sx_reg;
        wr_data.h     = item_sy_reg;
        wr_data.c     = cos_reg;
        wr_data.s     = sin_reg;
        wr_data.layer = item_layer_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_slot_reg  <= req.slot;
            item_px_reg    <= req.pos_x;
            item_py_reg    <= req.pos_y;
            item_sx_reg    <= req.size_x;
            item_sy_reg    <= req.size_y;
            item_layer_reg <= req.layer;
            item_pick_reg  <= req.pickable;
            item_adv_reg   <= req.advance;
        end
        if (cordic_done)
        begin
            cos_reg <= cordic_cos;
            sin_reg <= cordic_sin;
        end
        layer_k_reg <= layer_k_next;
        cidx_reg    <= cidx_next;
        oslot_reg   <= oslot_next;
        ototal_reg  <= ototal_next;
        ofound_reg  <= ofound_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            j_reg          <= '0;
            cmpv_reg       <= 1'b0;
            rank_reg       <= '0;
            total_reg      <= '0;
            want_reg       <= '0;
            last_valid_reg <= 1'b0;
            last_pick_reg  <= '0;
            found_reg      <= 1'b0;
            hit_reg        <= '0;
            en_reg         <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            j_reg          <= j_next;
            cmpv_reg       <= cmpv_next;
            rank_reg       <= rank_next;
            total_reg      <= total_next;
            want_reg       <= want_next;
            last_valid_reg <= last_valid_next;
            last_pick_reg  <= last_pick_next;
            found_reg      <= found_next;
            hit_reg        <= hit_next;
            en_reg         <= en_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // A slot in the sweep outranks the candidate when it is a hit with a
    // higher layer, or the same layer and a lower slot.
    assign beats = hit_reg[cidx_reg] && (cidx_reg != k_idx)
                   && ((rd_data_reg.layer > layer_k_reg)
                       || ((rd_data_reg.layer == layer_k_reg) && (cidx_reg < k_idx)));

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        cidx_next       = cidx_reg;
        cmpv_next       = 1'b0;
        rank_next       = rank_reg;
        total_next      = total_reg;
        want_next       = want_reg;
        last_valid_next = last_valid_reg;
        last_pick_next  = last_pick_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        en_next         = en_reg;
        layer_k_next    = layer_k_reg;
        ovalid_next     = ovalid_reg;
        ofound_next     = ofound_reg;
        oslot_next      = oslot_reg;
        ototal_next     = ototal_reg;
        rd_en           = 1'b0;
        rd_addr         = k_idx;
        wr_en           = 1'b0;
        hit_start       = 1'b0;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        if (cmpv_reg && beats)
        begin
            rank_next = rank_reg + 7'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!req.func)
                    begin
                        state_next = ST_CORDIC;
                    end
                    else
                    begin
                        hit_next   = '0;
                        total_next = '0;
                        k_next     = '0;
                        state_next = ST_TRD;
                    end
                end
            end
            ST_CORDIC:
            begin
                if (cordic_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (slot_ok)
                begin
                    wr_en = 1'b1;
                    en_next[item_slot_reg[AW-1:0]] = item_pick_reg;
                end
                state_next = ST_IDLE;
            end
            ST_TRD:
            begin
                // Slots that cannot be picked are passed over without a table read.
                if (en_reg[k_idx])
                begin
                    rd_en      = 1'b1;
                    state_next = ST_TSTART;
                end
                else if (k_reg == CW'(DEPTH - 1))
                begin
                    state_next = ST_TEVAL;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_TSTART:
            begin
                hit_start  = 1'b1;
                state_next = ST_TWAIT;
            end
            ST_TWAIT:
            begin
                if (hit_res.done)
                begin
                    hit_next[k_idx] = hit_res.hit;
                    total_next      = total_reg + 7'(hit_res.hit);
                    if (k_reg == CW'(DEPTH - 1))
                    begin
                        state_next = ST_TEVAL;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_TRD;
                    end
                end
            end
            ST_TEVAL:
            begin
                if (total_reg == '0)
                begin
                    last_valid_next = 1'b0;
                    last_pick_next  = '0;
                    found_next      = 1'b0;
                    state_next      = ST_OUT;
                end
                else
                begin
                    want_next  = (item_adv_reg && last_valid_reg) ? last_pick_reg + 7'd1 : '0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                // Remainder by repeated subtraction of the hit count.
                if (want_reg >= total_reg)
                begin
                    want_next = want_reg - total_reg;
                end
                else
                begin
                    last_valid_next = 1'b1;
                    last_pick_next  = want_reg;
                    k_next          = '0;
                    state_next      = ST_RK;
                end
            end
            ST_RK:
            begin
                if (hit_reg[k_idx])
                begin
                    rd_en      = 1'b1;
                    state_next = ST_RKLD;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_RKLD:
            begin
                layer_k_next = rd_data_reg.layer;
                j_next       = '0;
                rank_next    = '0;
                state_next   = ST_RSW;
            end
            ST_RSW:
            begin
                // Reads are issued back to back; each compare follows in the cycle after its read.
                rd_en     = 1'b1;
                rd_addr   = j_reg[AW-1:0];
                cidx_next = j_reg[AW-1:0];
                cmpv_next = 1'b1;
                j_next    = j_reg + 1'b1;
                if (j_reg == CW'(DEPTH - 1))
                begin
                    state_next = ST_RDRAIN;
                end
            end
            ST_RDRAIN:
            begin
                state_next = ST_RCHK;
            end
            ST_RCHK:
            begin
                if (rank_reg == want_reg)
                begin
                    found_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_RK;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ofound_next = found_reg;
                    oslot_next  = found_reg ? 6'(k_idx) : '0;
                    ototal_next = total_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid       = ovalid_reg;
    assign rsp.found       = ofound_reg;
    assign rsp.picked_slot = oslot_reg;
    assign rsp.hit_total   = ototal_reg;

    // A result that reports a hit also reports a nonzero count.
    a_found_total: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (rsp.hit_total != '0))
        else $error("found result with zero hit count");

    // A miss reports slot and count as zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.picked_slot == '0 && rsp.hit_total == '0))
        else $error("miss result with nonzero fields");

    // The hit count never exceeds the table depth.
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= 7'(DEPTH))
        else $error("hit count beyond table depth");

    // Ranking only runs with a wanted rank below the hit count.
    a_want_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RCHK) |-> (want_reg < total_reg))
        else $error("wanted rank not below hit count");

endmodule

`default_nettype wire

/* design/pps_cordic.sv */
// Iterative CORDIC: turns an angle in 1/256 degree into Q1.16 cosine and sine.
// One shift-add step per cycle; depends on pps_pkg.
`default_nettype none

module pps_cordic (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [16:0]        angle,
    output logic                    done,
    output logic signed [17:0]      cos_val,
    output logic signed [17:0]      sin_val
);
    import pps_pkg::*;

    pps_cordic_state_t  state_reg, state_next;
    logic [16:0]        a_reg, a_next;
    logic [1:0]         q_reg, q_next;
    logic signed [19:0] x_reg, x_next;
    logic signed [19:0] y_reg, y_next;
    logic signed [24:0] z_reg, z_next;
    logic [3:0]         i_reg, i_next;
    logic signed [19:0] dx, dy;
    logic [16:0]        r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        q_reg <= q_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
    end

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        q_next     = q_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        i_next     = i_reg;
        r          = a_reg;
        done       = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    a_next     = (angle >= 17'(TURN)) ? angle - 17'(TURN) : angle;
                    state_next = CS_PREP;
                end
            end
            CS_PREP:
            begin
                // Split the reduced angle into quadrant and remainder.
                if (a_reg >= 17'(3 * QUARTER))
                begin
                    q_next = 2'd3;
                    r      = a_reg - 17'(3 * QUARTER);
                end
                else if (a_reg >= 17'(2 * QUARTER))
                begin
                    q_next = 2'd2;
                    r      = a_reg - 17'(2 * QUARTER);
                end
                else if (a_reg >= 17'(QUARTER))
                begin
                    q_next = 2'd1;
                    r      = a_reg - 17'(QUARTER);
                end
                else
                begin
                    q_next = 2'd0;
                    r      = a_reg;
                end
                z_next     = $signed({r, 8'b0});
                x_next     = 20'sd39797;
                y_next     = '0;
                i_next     = '0;
                state_next = CS_ITER;
            end
            CS_ITER:
            begin
                if (!z_reg[24])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_at(i_reg);
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_at(i_reg);
                end
                i_next = i_reg + 4'd1;
                if (i_reg == 4'(CORDIC_STEPS - 1))
                begin
                    state_next = CS_DONE;
                end
            end
            CS_DONE:
            begin
                done       = 1'b1;
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Quadrant fold of the first-quadrant vector.
    always_comb
    begin
        unique case (q_reg)
            2'd0:
            begin
                cos_val = 18'(x_reg);
                sin_val = 18'(y_reg);
            end
            2'd1:
            begin
                cos_val = 18'(-y_reg);
                sin_val = 18'(x_reg);
            end
            2'd2:
            begin
                cos_val = 18'(-x_reg);
                sin_val = 18'(-y_reg);
            end
            default:
            begin
                cos_val = 18'(y_reg);
                sin_val = 18'(-x_reg);
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/pps_hit.sv */
// Containment test of one point against one rotated rectangle.
// Four products through one shared multiplier; depends on pps_pkg.
`default_nettype none

module pps_hit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [23:0]  px,
    input  wire logic signed [23:0]  py,
    input  wire pps_pkg::pps_entry_t entry,
    output pps_pkg::pps_hit_res_t    res
);
    import pps_pkg::*;

    logic               busy_reg, busy_next;
    logic [2:0]         step_reg, step_next;
    logic signed [24:0] ox_reg, oy_reg;
    logic signed [17:0] c_reg, s_reg;
    logic [15:0]        w_reg, h_reg;
    logic signed [42:0] prod_reg, acc_reg;
    logic signed [43:0] lx_reg, ly_reg;
    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] mul_p;
    logic [43:0]        abs_x, abs_y, lim_x, lim_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end
        else if (step_reg == 3'd5)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            step_next = step_reg + 3'd1;
        end
    end

    // Operand order: ox*c, oy*s, oy*c, ox*s.
    assign mul_a = (step_reg == 3'd0 || step_reg == 3'd3) ? ox_reg : oy_reg;
    assign mul_b = (step_reg == 3'd0 || step_reg == 3'd2) ? c_reg : s_reg;
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            ox_reg <= 25'(px) - 25'(entry.cx);
            oy_reg <= 25'(py) - 25'(entry.cy);
            c_reg  <= entry.c;
            s_reg  <= entry.s;
            w_reg  <= entry.w;
            h_reg  <= entry.h;
        end
        if (busy_reg)
        begin
            prod_reg <= mul_p;
            unique case (step_reg)
                3'd1:    acc_reg <= prod_reg;
                3'd2:    lx_reg  <= 44'(acc_reg) + 44'(prod_reg);
                3'd3:    acc_reg <= prod_reg;
                3'd4:    ly_reg  <= 44'(acc_reg) - 44'(prod_reg);
                default: ;
            endcase
        end
    end

    assign abs_x = lx_reg[43] ? 44'(-lx_reg) : 44'(lx_reg);
    assign abs_y = ly_reg[43] ? 44'(-ly_reg) : 44'(ly_reg);
    // Twice the magnitude against size*65536 is the magnitude against size*32768.
    assign lim_x = {13'b0, w_reg, 15'b0};
    assign lim_y = {13'b0, h_reg, 15'b0};

    assign res.done = busy_reg && (step_reg == 3'd5);
    assign res.hit  = (w_reg != '0) && (h_reg != '0) && (abs_x <= lim_x) && (abs_y <= lim_y);

endmodule

`default_nettype wire

/* sim/pps_checker.sv */
// Checker for the rotated-rectangle point picker: watches both channels,
// predicts each result from its own copy of the slot table and compares.
// Depends on pps_pkg, pps_in_if and pps_out_if.
`default_nettype none

module pps_checker #(
    parameter int SLOTS = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pps_in_if.sink    req_mon,
    pps_out_if.sink   rsp_mon,
    output int        fail_count,
    output int        pending
);

    typedef struct {
        logic       found;
        logic [5:0] picked_slot;
        logic [6:0] hit_total;
    } pick_t;

    logic signed [23:0] tab_cx [SLOTS];
    logic signed [23:0] tab_cy [SLOTS];
    logic [15:0]        tab_w  [SLOTS];
    logic [15:0]        tab_h  [SLOTS];
    logic signed [17:0] tab_c  [SLOTS];
    logic signed [17:0] tab_s  [SLOTS];
    logic signed [15:0] tab_layer [SLOTS];
    logic               tab_en [SLOTS];
    logic               prev_valid;
    int                 prev_rank;
    pick_t              picks_due[$];

    function automatic longint atan_val(input int i);
        longint t [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return t[i];
    endfunction

    task automatic rotate_angle(input logic [16:0] ang, output logic signed [17:0] c,
                                output logic signed [17:0] s);
        longint a, q, z, x, y, dx, dy;
        a = ang % pps_pkg::TURN;
        q = a / pps_pkg::QUARTER;
        z = (a % pps_pkg::QUARTER) * 256;
        x = pps_pkg::CORDIC_X0;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_val(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_val(i);
            end
        end
        case (q)
            0: begin c = 18'(x);  s = 18'(y);  end
            1: begin c = 18'(-y); s = 18'(x);  end
            2: begin c = 18'(-x); s = 18'(-y); end
            default: begin c = 18'(y); s = 18'(-x); end
        endcase
    endtask

    function automatic bit inside_rect(input int k, input longint px, input longint py);
        longint ox, oy, lx, ly;
        if (tab_w[k] == 0 || tab_h[k] == 0) return 0;
        ox = px - tab_cx[k];
        oy = py - tab_cy[k];
        lx = ox * tab_c[k] + oy * tab_s[k];
        ly = oy * tab_c[k] - ox * tab_s[k];
        if (lx < 0) lx = -lx;
        if (ly < 0) ly = -ly;
        return (2 * lx <= longint'(tab_w[k]) * 65536) && (2 * ly <= longint'(tab_h[k]) * 65536);
    endfunction

    task automatic predict_pick(input longint px, input longint py, input logic adv);
        bit    hit [SLOTS];
        int    total, want, rank;
        pick_t p;
        total = 0;
        p = '{1'b0, 6'd0, 7'd0};
        for (int k = 0; k < SLOTS; k++)
        begin
            hit[k] = tab_en[k] && inside_rect(k, px, py);
            if (hit[k]) total++;
        end
        if (total == 0)
        begin
            prev_valid = 0;
            prev_rank = 0;
        end
        else
        begin
            want = (adv && prev_valid) ? (prev_rank + 1) % total : 0;
            for (int k = 0; k < SLOTS; k++)
            begin
                if (!hit[k]) continue;
                rank = 0;
                for (int j = 0; j < SLOTS; j++)
                    if (hit[j] && j != k && (tab_layer[j] > tab_layer[k] ||
                        (tab_layer[j] == tab_layer[k] && j < k)))
                        rank++;
                if (rank == want)
                begin
                    p.picked_slot = 6'(k);
                    break;
                end
            end
            prev_valid = 1;
            prev_rank = want;
            p.found = 1;
            p.hit_total = 7'(total);
        end
        picks_due = {picks_due, p};
    endtask

    assign pending = picks_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        pick_t exp_p;
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                tab_cx[k] = 0; tab_cy[k] = 0; tab_w[k] = 0; tab_h[k] = 0;
                tab_c[k] = 0; tab_s[k] = 0; tab_layer[k] = 0; tab_en[k] = 0;
            end
            prev_valid = 0;
            prev_rank = 0;
            fail_count = 0;
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
            begin
                if (req_mon.func == 1'b0)
                begin
                    if (req_mon.slot < SLOTS)
                    begin
                        tab_cx[req_mon.slot] = req_mon.pos_x;
                        tab_cy[req_mon.slot] = req_mon.pos_y;
                        tab_w[req_mon.slot] = req_mon.size_x;
                        tab_h[req_mon.slot] = req_mon.size_y;
                        rotate_angle(req_mon.angle, tab_c[req_mon.slot], tab_s[req_mon.slot]);
                        tab_layer[req_mon.slot] = req_mon.layer;
                        tab_en[req_mon.slot] = req_mon.pickable;
                    end
                end
                else
                    predict_pick(req_mon.pos_x, req_mon.pos_y, req_mon.advance);
            end
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (picks_due.size() == 0)
                begin
                    $error("unexpected result word");
                    fail_count++;
                end
                else
                begin
                    exp_p = picks_due.pop_front();
                    if (rsp_mon.found !== exp_p.found)
                    begin
                        $error("found: expected %0d actual %0d", exp_p.found, rsp_mon.found);
                        fail_count++;
                    end
                    if (rsp_mon.picked_slot !== exp_p.picked_slot)
                    begin
                        $error("picked_slot: expected %0d actual %0d",
                               exp_p.picked_slot, rsp_mon.picked_slot);
                        fail_count++;
                    end
                    if (rsp_mon.hit_total !== exp_p.hit_total)
                    begin
                        $error("hit_total: expected %0d actual %0d",
                               exp_p.hit_total, rsp_mon.hit_total);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Top of the point picker testbench: clock, reset, stimulus and verdict.
// Depends on pps_pkg, pps_in_if, pps_out_if, pps_checker and the block itself.
`default_nettype none

module testbench;

    localparam int SLOTS       = 64;
    localparam int RANDOM_WORDS = 120;
    // The limit sits several times above the longest query on a full table;
    // it bounds the quiet stretch in which no word moves on either channel.
    localparam int STALL_LIMIT = 40000;
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;
    bit   calm = 0;

    pps_in_if  req ();
    pps_out_if rsp ();

    point_pick_rotated_sprites_top #(.SLOTS(SLOTS)) dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source)
    );

    pps_checker #(.SLOTS(SLOTS)) checker_i (
        .clk(clk), .rst_n(rst_n), .req_mon(req.sink), .rsp_mon(rsp.sink),
        .fail_count(fail_count), .pending(pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        req.valid = 1'b0; req.func = 1'b0; req.slot = '0; req.pos_x = '0; req.pos_y = '0;
        req.size_x = '0; req.size_y = '0; req.angle = '0; req.layer = '0;
        req.pickable = 1'b0; req.advance = 1'b0;
        rsp.ready = 1'b0;
    end

    // The receiver stalls in random bursts, except in the calm closing stretch.
    always @(posedge clk)
    begin
        int burst;
        if (rst_n)
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                burst = $urandom_range(1, 6);
                repeat (burst) @(posedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    // The watchdog counts cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sends one word and holds it until the block accepts it. Between words
    // the sender idles now and then for a short burst; otherwise valid stays
    // high and the next word follows right away.
    task automatic send_word(input logic fn, input logic [5:0] sl, input logic [23:0] px,
                             input logic [23:0] py, input logic [15:0] sx,
                             input logic [15:0] sy, input logic [16:0] ang,
                             input logic [15:0] lay, input logic pk, input logic adv);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid <= 1'b1; req.func <= fn; req.slot <= sl; req.pos_x <= px;
        req.pos_y <= py; req.size_x <= sx; req.size_y <= sy; req.angle <= ang;
        req.layer <= lay; req.pickable <= pk; req.advance <= adv;
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic load_slot(input int sl, input int px, input int py, input int sx,
                             input int sy, input int ang, input int lay, input bit pk);
        send_word(FUNC_LOAD, 6'(sl), 24'(px), 24'(py), 16'(sx), 16'(sy), 17'(ang),
                  16'(lay), pk, 1'b0);
    endtask

    task automatic query_point(input int px, input int py, input bit adv);
        send_word(FUNC_QUERY, 6'($urandom), 24'(px), 24'(py), 16'($urandom),
                  16'($urandom), 17'($urandom), 16'($urandom), 1'($urandom), adv);
    endtask

    initial
    begin
        int kind, sl, cx, cy;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A query on the empty table finds nothing.
        query_point(0, 0, 1);
        // Overlapping rectangles at the origin with mixed layers, so the rank
        // order and the advance wraparound are exercised.
        load_slot(0, 0, 0, 16'h0400, 16'h0400, 0, 5, 1);
        load_slot(63, 0, 0, 16'hFFFF, 16'hFFFF, 92159, 5, 1);
        load_slot(10, 256, 0, 16'h0800, 16'h0200, 11520, 16'sh7FFF, 1);
        load_slot(20, 0, 0, 16'h0200, 16'h0200, 46080, -32768, 1);
        load_slot(30, 0, 0, 16'h0000, 16'h0400, 23040, 9, 1);
        load_slot(31, 0, 0, 16'h0400, 16'h0000, 69120, 9, 1);
        load_slot(40, 0, 0, 16'h0400, 16'h0400, 80000, 100, 0);
        load_slot(41, 24'h7FFFFF, 24'h800000, 16'h0100, 16'h0100, 131071, 3, 1);
        query_point(0, 0, 0);
        query_point(0, 0, 1);
        query_point(0, 0, 1);
        query_point(0, 0, 1);
        query_point(0, 0, 1);
        // Edge of the axis-aligned square: exactly on the boundary is a hit.
        query_point(512, 0, 0);
        query_point(513, 0, 1);
        query_point(24'h7FFFFF, 24'h800000, 1);
        query_point(24'h800000, 24'h7FFFFF, 1);
        // A miss clears the earlier pick, so advance restarts at rank 0.
        query_point(24'h400000, 24'h400000, 1);
        query_point(0, 0, 1);

        // Random part: mostly loads near a few clusters and queries near
        // them, so that overlaps and several hits are common.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n > RANDOM_WORDS - 20) calm = 1;
            kind = $urandom_range(0, 9);
            cx = $urandom_range(0, 3) * 2048 - 3072;
            cy = $urandom_range(0, 3) * 2048 - 3072;
            if (kind < 5)
            begin
                sl = $urandom_range(0, 15) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 15);
                if (kind == 0)
                    load_slot(sl, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, 1'($urandom));
                else
                    load_slot(sl, cx + $signed($urandom_range(0, 1024)) - 512,
                              cy + $signed($urandom_range(0, 1024)) - 512,
                              $urandom_range(0, 8191), $urandom_range(0, 8191),
                              $urandom_range(0, 131071), $signed($urandom_range(0, 7)) - 3,
                              $urandom_range(0, 7) != 0);
            end
            else if (kind == 5)
                query_point($urandom, $urandom, 1'($urandom));
            else
                query_point(cx + $signed($urandom_range(0, 1024)) - 512,
                            cy + $signed($urandom_range(0, 1024)) - 512,
                            $urandom_range(0, 3) != 0);
        end

        req.valid <= 1'b0;
        calm = 1;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

/* point_pick_rotated_sprites_top.f */
design/pps_pkg.sv
design/pps_in_if.sv
design/pps_out_if.sv
design/pps_cordic.sv
design/pps_hit.sv
design/point_pick_rotated_sprites_top.sv
sim/pps_checker.sv
sim/testbench.sv
